/* src/minkowski_distance_accumulator_unit_defines.svh */
// Assertion macros used by the top-level RTL
`ifndef MINKOWSKI_DISTANCE_ACCUMULATOR_UNIT_DEFINES_SVH
`define MINKOWSKI_DISTANCE_ACCUMULATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MDACC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MDACC_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define MDACC_ASSERT(lbl, clk, rst, prop, msg)
`define MDACC_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

/* src/mdacc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mdacc_pkg;

  localparam int SUM_W  = 48;
  localparam int DIST_W = 32;
  localparam int CFG_W  = 17;
  localparam int EXP_W  = 16;

  localparam logic [63:0] SUM_MAX  = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] DIST_MAX = (64'd1 << DIST_W) - 64'd1;

  localparam logic CFG_EXPONENT     = 1'b0;
  localparam logic CFG_INV_EXPONENT = 1'b1;

  typedef logic [16:0][31:0] exp2_rom_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bit_v;
    n = n_in;
    r = '0;
    bit_v = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  // entry i holds 2^(2^-i) in Q2.30
  function automatic exp2_rom_t gen_exp2_rom();
    exp2_rom_t rom;
    logic [63:0] sq;
    rom[0] = 32'h8000_0000;
    for (int i = 1; i <= 16; i++) begin
      sq = isqrt64({32'd0, rom[i-1]} << 30);
      rom[i] = sq[31:0];
    end
    return rom;
  endfunction

  localparam exp2_rom_t EXP2_ROM = gen_exp2_rom();

endpackage
`default_nettype wire

/* src/mdacc_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
interface mdacc_in_if #(parameter int DW = 32);
  logic          valid;
  logic          ready;
  logic [DW-1:0] x_elem;
  logic [DW-1:0] y_elem;
  logic          last_elem;
  modport source(output valid, x_elem, y_elem, last_elem, input ready);
  modport sink(input valid, x_elem, y_elem, last_elem, output ready);
endinterface

interface mdacc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic        overflow;
  modport source(output valid, distance, overflow, input ready);
  modport sink(input valid, distance, overflow, output ready);
endinterface
`default_nettype wire

/* src/mdacc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module mdacc_front #(
  parameter int DW = 32
) (
  mdacc_in_if.sink     in_ch,
  input  logic         q_full,
  output logic         q_push,
  output logic [DW+1:0] q_entry
);
  logic signed [DW:0] diff;
  logic [DW-1:0] mag;

  assign diff = $signed({in_ch.x_elem[DW-1], in_ch.x_elem})
              - $signed({in_ch.y_elem[DW-1], in_ch.y_elem});
  // |x-y| never exceeds 2^DW-1
  always_comb begin
    logic [DW:0] neg;
    neg = -diff;
    mag = diff[DW] ? neg[DW-1:0] : diff[DW-1:0];
  end

  assign in_ch.ready = !q_full;
  assign q_push  = in_ch.valid && !q_full;
  // entry: last, zero, magnitude
  assign q_entry = {in_ch.last_elem, (mag == '0), mag};
endmodule
`default_nettype wire

/* src/mdacc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module mdacc_queue #(
  parameter int W = 34,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       not_empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign not_empty = (count != '0);
  assign full      = (count == CW'(DEPTH));
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

/* src/mdacc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module mdacc_back import mdacc_pkg::*; #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [DW+1:0]     q_entry,
  output logic              q_pop,
  input  logic [EXP_W-1:0]  exponent,
  input  logic [CFG_W-1:0]  inv_exponent,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] distance,
  output logic              overflow
);
  localparam int AW = (DW > SUM_W) ? DW : SUM_W;
  localparam int SW = $clog2(AW+1);

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_LOG, S_SCALE, S_EXP, S_SHIFT, S_CHK, S_OUT
  } state_t;

  state_t state;
  logic              mode_root;
  logic              last_q;
  logic [AW-1:0]     norm;
  logic [SW-1:0]     shcnt;
  logic [31:0]       z;
  logic [15:0]       frac;
  logic [3:0]        cnt;
  logic signed [41:0] tval;
  logic [30:0]       m;
  logic [SUM_W-1:0]  power_sum;
  logic              sat_seen;
  logic [DIST_W-1:0] res_dist;
  logic              res_ovf;

  // squaring step of log2
  logic [61:0] sq;
  logic [31:0] zs;
  assign sq = z[30:0] * z[30:0];
  assign zs = sq[61:30];

  // scaling by p or 1/p
  logic signed [7:0]  ip;
  logic signed [23:0] lval;
  logic [CFG_W-1:0]   mult;
  logic signed [41:0] prod;
  assign ip   = 8'(AW-1) - 8'(shcnt) - 8'(FB);
  assign lval = {ip, frac};
  assign mult = mode_root ? inv_exponent : {1'b0, exponent};
  assign prod = lval * $signed({1'b0, mult});

  // exp2 fraction step
  logic [4:0]  ridx;
  logic [62:0] mprod;
  assign ridx  = 5'(cnt) + 5'd1;
  assign mprod = m * EXP2_ROM[ridx];

  // final shift and saturation
  logic signed [25:0] n_int;
  logic signed [26:0] sh;
  logic [63:0] maxval;
  logic [63:0] v;
  logic        sat;
  logic [SUM_W-1:0] headroom;
  logic [5:0] rsh;
  assign n_int = 26'(tval >>> 16);
  assign sh = 27'(n_int) + 27'(FB) - 27'sd30;
  assign maxval = mode_root ? DIST_MAX : SUM_MAX;
  assign headroom = SUM_MAX[SUM_W-1:0] - power_sum;
  assign rsh = 6'(-sh);

  always_comb begin
    logic [63:0] shifted;
    v = '0;
    sat = 1'b0;
    shifted = '0;
    if (sh > 27'sd32) begin
      v = maxval;
      sat = 1'b1;
    end else if (sh >= 27'sd0) begin
      shifted = {33'd0, m} << sh[5:0];
      if (shifted > maxval) begin
        v = maxval;
        sat = 1'b1;
      end else begin
        v = shifted;
      end
    end else if (sh > -27'sd32) begin
      v = {33'd0, m} >> rsh;
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      power_sum <= '0;
      sat_seen  <= 1'b0;
      out_valid <= 1'b0;
      mode_root <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            last_q    <= q_entry[DW+1];
            mode_root <= 1'b0;
            norm      <= AW'(q_entry[DW-1:0]);
            shcnt     <= '0;
            state     <= q_entry[DW] ? S_CHK : S_NORM;
          end
        end
        S_NORM: begin
          if (norm[AW-1]) begin
            z     <= {1'b0, norm[AW-1 -: 31]};
            frac  <= '0;
            cnt   <= '0;
            state <= S_LOG;
          end else if (norm[AW-1 -: 8] == 8'd0) begin
            norm  <= norm << 8;
            shcnt <= shcnt + SW'(8);
          end else begin
            norm  <= norm << 1;
            shcnt <= shcnt + SW'(1);
          end
        end
        S_LOG: begin
          if (zs[31]) begin
            z    <= {1'b0, zs[31:1]};
            frac <= {frac[14:0], 1'b1};
          end else begin
            z    <= zs;
            frac <= {frac[14:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 4'd15) state <= S_SCALE;
        end
        S_SCALE: begin
          tval  <= mode_root ? (prod >>> 16) : (prod >>> 12);
          m     <= 31'h4000_0000;
          cnt   <= '0;
          state <= S_EXP;
        end
        S_EXP: begin
          if (tval[4'd15 - cnt]) m <= mprod[60:30];
          cnt <= cnt + 1'b1;
          if (cnt == 4'd15) state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (mode_root) begin
            res_dist <= v[DIST_W-1:0];
            res_ovf  <= sat || sat_seen;
            state    <= S_OUT;
          end else begin
            if (v > {16'd0, headroom}) begin
              power_sum <= SUM_MAX[SUM_W-1:0];
              sat_seen  <= 1'b1;
            end else begin
              power_sum <= power_sum + v[SUM_W-1:0];
              if (sat) sat_seen <= 1'b1;
            end
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (power_sum == '0) begin
            res_dist <= '0;
            res_ovf  <= sat_seen;
            state    <= S_OUT;
          end else begin
            mode_root <= 1'b1;
            norm      <= AW'(power_sum);
            shcnt     <= '0;
            state     <= S_NORM;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            distance  <= res_dist;
            overflow  <= res_ovf;
            power_sum <= '0;
            sat_seen  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/minkowski_distance_accumulator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "minkowski_distance_accumulator_unit_defines.svh"
// Minkowski distance accumulator. Each input beat carries one element pair of
// two vectors; the front computes |x-y| and queues it, the back engine turns
// it into |x-y|^p with an iterative log2 (16 squarings), one scaling multiply
// and an iterative exp2 (16 table multiplies), then adds it to a saturating
// 48-bit sum. A pair with zero difference skips the log2 and exp2 steps and
// goes straight to the last-beat check; for any other pair the length of the
// normalization is set by the position of the top set bit. The beat marked
// last runs the same engine once more for the p-th root. The input queue keeps
// accepting while the engine works or while a result waits on the output
// register, until it is full. exponent (Q4.12) and inv_exponent (Q1.16) must
// be written consistently by software while the block is idle.
module minkowski_distance_accumulator_unit import mdacc_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  mdacc_in_if.sink         in_ch,
  mdacc_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);
  localparam int QW = DATA_WIDTH + 2;
  localparam int CW = $clog2(QUEUE_DEPTH+1);

  logic [EXP_W-1:0] exponent;
  logic [CFG_W-1:0] inv_exponent;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent     <= EXP_W'(8192);
      inv_exponent <= CFG_W'(32768);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPONENT:     exponent     <= cfg_wdata[EXP_W-1:0];
        CFG_INV_EXPONENT: inv_exponent <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic          q_push, q_pop, q_full, q_valid;
  logic [QW-1:0] q_wdata, q_rdata;
  logic [CW-1:0] q_count;

  mdacc_front #(.DW(DATA_WIDTH)) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_entry(q_wdata)
  );

  mdacc_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .not_empty(q_valid),
    .full     (q_full),
    .count    (q_count)
  );

  mdacc_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_rdata),
    .q_pop       (q_pop),
    .exponent    (exponent),
    .inv_exponent(inv_exponent),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .distance    (out_ch.distance),
    .overflow    (out_ch.overflow)
  );

  `MDACC_NEVER(a_no_ready_when_full, clk, rst, q_full && in_ch.ready, "ready while queue full")
  `MDACC_NEVER(a_count_bound, clk, rst, q_count > CW'(QUEUE_DEPTH), "queue count overrun")
  `MDACC_ASSERT(a_push_lands, clk, rst, (in_ch.valid && in_ch.ready && q_count == '0) |=> (q_count != '0), "beat lost")
  `MDACC_NEVER(a_pop_empty, clk, rst, q_pop && !q_valid, "pop from empty queue")
endmodule
`default_nettype wire

/* tb/tb_minkowski_distance_accumulator_unit.sv */
`timescale 1ns / 1ps
module tb_minkowski_distance_accumulator_unit;
  import mdacc_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } pair_t;

  typedef struct packed {
    logic [31:0] dval;
    logic        ovf;
  } dist_t;

  localparam logic [63:0] SUM_TOP  = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] DIST_TOP = 64'hFFFF_FFFF;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  mdacc_in_if #(.DW(32)) in_if ();
  mdacc_out_if out_if ();

  minkowski_distance_accumulator_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  pair_t pair_q[$];
  dist_t dist_q[$];
  int    errors = 0;

  // predictor state
  logic [63:0] acc_sum;
  logic        acc_sat;
  logic [15:0] p_q412;
  logic [16:0] invp_q116;
  logic [63:0] root_rom[17];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem = v;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint log2_q16(input logic [63:0] a);
    int b;
    logic [63:0] z;
    longint frac;
    b = 63;
    frac = 0;
    while (b > 0 && !a[b]) b--;
    if (b >= 30) z = a >> (b - 30);
    else z = a << (30 - b);
    for (int i = 0; i < 16; i++) begin
      z = (z * z) >> 30;
      frac = frac << 1;
      if (z >= (64'd1 << 31)) begin
        z = z >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(b) - 16) * 65536 + frac;
  endfunction

  function automatic logic [63:0] exp2_q16(input longint t, input logic [63:0] maxv,
                                           output logic sat);
    longint n;
    logic [63:0] f;
    logic [63:0] m;
    logic [63:0] v;
    longint s;
    sat = 1'b0;
    n = t >>> 16;
    f = t - n * 65536;
    m = 64'd1 << 30;
    for (int i = 1; i <= 16; i++)
      if (f[16-i]) m = (m * root_rom[i]) >> 30;
    s = n + 16 - 30;
    if (s >= 0) begin
      if (s > 32) begin
        sat = 1'b1;
        return maxv;
      end
      v = m << s;
    end else begin
      if (s <= -32) return 0;
      v = m >> (-s);
    end
    if (v > maxv) begin
      sat = 1'b1;
      return maxv;
    end
    return v;
  endfunction

  function automatic void accumulate_pair(input pair_t it);
    longint d;
    logic [63:0] mag;
    logic [63:0] term;
    logic sat;
    longint t;
    dist_t r;
    d = longint'($signed(it.x)) - longint'($signed(it.y));
    mag = d < 0 ? -d : d;
    if (mag != 0) begin
      t = (log2_q16(mag) * longint'({1'b0, p_q412})) >>> 12;
      term = exp2_q16(t, SUM_TOP, sat);
      if (sat) acc_sat = 1'b1;
      if (term > SUM_TOP - acc_sum) begin
        acc_sum = SUM_TOP;
        acc_sat = 1'b1;
      end else begin
        acc_sum = acc_sum + term;
      end
    end
    if (it.last) begin
      r.dval = '0;
      sat = 1'b0;
      if (acc_sum != 0) begin
        t = (log2_q16(acc_sum) * longint'({1'b0, invp_q116})) >>> 16;
        r.dval = exp2_q16(t, DIST_TOP, sat);
      end
      r.ovf = sat | acc_sat;
      dist_q.push_back(r);
      acc_sum = 0;
      acc_sat = 1'b0;
    end
  endfunction

  // sender: bursts with random gaps
  int burst_left;
  int gap_left;
  logic hold_send;
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      in_if.x_elem <= '0;
      in_if.y_elem <= '0;
      in_if.last_elem <= 1'b0;
      burst_left <= 8;
      gap_left <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        accumulate_pair('{in_if.x_elem, in_if.y_elem, in_if.last_elem});
        void'(pair_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      if (gap_left > 0 && !(in_if.valid && !in_if.ready)) begin
        in_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pair_q.size() > 0 &&
                   (!hold_send || (in_if.valid && !in_if.ready))) begin
        // a stalled beat stays up even when a hold is requested
        in_if.valid <= 1'b1;
        in_if.x_elem <= pair_q[0].x;
        in_if.y_elem <= pair_q[0].y;
        in_if.last_elem <= pair_q[0].last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern rotates through always-ready, mostly-ready and mostly-stalled phases; one long hold-off
  int cyc;
  int hold_left;
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      cyc <= 0;
      hold_left <= 0;
    end else begin
      cyc <= cyc + 1;
      if (out_if.valid && out_if.ready) begin
        if (dist_q.size() == 0) begin
          $error("distance beat with nothing expected: %h", out_if.distance);
          errors++;
        end else begin
          if (out_if.distance !== dist_q[0].dval) begin
            $error("distance: expected %h, got %h", dist_q[0].dval, out_if.distance);
            errors++;
          end
          if (out_if.overflow !== dist_q[0].ovf) begin
            $error("overflow: expected %b, got %b", dist_q[0].ovf, out_if.overflow);
            errors++;
          end
          void'(dist_q.pop_front());
        end
      end
      if (cyc == 4000) begin
        hold_left <= 600;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        case ((cyc / 700) % 3)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 9) < 7);
          default: out_if.ready <= ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_EXPONENT) p_q412 = val[15:0];
    else invp_q116 = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pair_q.size() > 0 || dist_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic pair_t rand_pair(input logic last);
    pair_t it;
    int kind;
    int sh;
    kind = $urandom_range(0, 19);
    it.x = $urandom;
    it.last = last;
    sh = $urandom_range(0, 24);
    if (kind < 3) it.y = $urandom;
    else if (kind < 5) it.y = it.x;
    else if (kind < 8) it.y = it.x - $urandom_range(1, 16) + 8;
    else it.y = it.x + ($urandom >> (8 + sh)) - ($urandom >> (8 + sh));
    return it;
  endfunction

  task automatic random_vectors(input int n_items);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) pair_q.push_back(rand_pair(k == len - 1));
      cnt += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_EXPONENT;
    cfg_wdata = '0;
    hold_send = 1'b0;
    acc_sum = 0;
    acc_sat = 1'b0;
    p_q412 = 16'd8192;
    invp_q116 = 17'd32768;
    root_rom[0] = 64'h8000_0000;
    for (int i = 1; i <= 16; i++) root_rom[i] = int_sqrt(root_rom[i-1] << 30);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero difference, lone last with empty sum
    pair_q.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 1'b1});
    pair_q.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 1'b1});
    pair_q.push_back('{32'h1234_5678, 32'h1234_5678, 1'b1});
    pair_q.push_back('{32'h8000_0000, 32'h8000_0000, 1'b0});
    pair_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    pair_q.push_back('{32'h0000_0001, 32'h0000_0000, 1'b1});
    pair_q.push_back('{32'h0001_0000, 32'h0000_0000, 1'b0});
    pair_q.push_back('{32'h0000_0000, 32'h0001_0000, 1'b0});
    pair_q.push_back('{32'h0002_8000, 32'hFFFF_0000, 1'b1});
    for (int k = 0; k < 6; k++) pair_q.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
    pair_q.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 1'b1});
    pair_q.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 1'b1});
    drain();

    random_vectors(200);
    drain();
    // p = 1
    write_reg(CFG_EXPONENT, 17'd4096);
    write_reg(CFG_INV_EXPONENT, 17'd65536);
    pair_q.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 1'b1});
    random_vectors(180);
    drain();
    // p = 3
    write_reg(CFG_EXPONENT, 17'd12288);
    write_reg(CFG_INV_EXPONENT, 17'd21845);
    random_vectors(180);
    drain();
    // largest p, smallest 1/p
    write_reg(CFG_EXPONENT, 17'd65535);
    write_reg(CFG_INV_EXPONENT, 17'd4096);
    pair_q.push_back('{32'h0000_0001, 32'h0000_0000, 1'b1});
    pair_q.push_back('{32'h0000_8000, 32'h0000_0000, 1'b1});
    random_vectors(170);
    drain();
    // p = 1.5
    write_reg(CFG_EXPONENT, 17'd6144);
    write_reg(CFG_INV_EXPONENT, 17'd43691);
    random_vectors(180);
    drain();
    // out-of-range settings used as written
    write_reg(CFG_EXPONENT, 17'd0);
    write_reg(CFG_INV_EXPONENT, 17'd131071);
    random_vectors(80);
    drain();
    write_reg(CFG_EXPONENT, 17'd1);
    write_reg(CFG_INV_EXPONENT, 17'd0);
    random_vectors(80);
    drain();
    // back to p = 2, with the sender held until everything arrives mid-phase
    write_reg(CFG_EXPONENT, 17'd8192);
    write_reg(CFG_INV_EXPONENT, 17'd32768);
    random_vectors(90);
    repeat (300) @(posedge clk);
    hold_send = 1'b1;
    @(posedge clk);
    while (in_if.valid) @(posedge clk);
    while (dist_q.size() > 0) @(posedge clk);
    hold_send = 1'b0;
    random_vectors(90);
    drain();

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb_minkowski_distance_accumulator_unit: PASS");
    end else begin
      $display("tb_minkowski_distance_accumulator_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_minkowski_distance_accumulator_unit: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/mdacc_pkg.sv
src/mdacc_ifs.sv
src/mdacc_front.sv
src/mdacc_queue.sv
src/mdacc_back.sv
src/minkowski_distance_accumulator_unit.sv
tb/tb_minkowski_distance_accumulator_unit.sv
